FILE: src/efcrc8_pkg.sv
package efcrc8_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 1500;
   localparam int unsigned MIN_PAYLOAD_DEF = 46;

   localparam int unsigned ADDR_W = 48;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 11;

   localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hAA;
   localparam logic [BYTE_W-1:0] SFD_BYTE      = 8'hAB;

   localparam logic [ADDR_W-1:0] DEST_ADDR_RESET = 48'h0000_E486_3ADC;
   localparam logic [ADDR_W-1:0] SRC_ADDR_RESET  = 48'h0000_801A_E665;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ADDR  = 1'b1;

   typedef struct packed {
      logic              clear;
      logic              update;
      logic [BYTE_W-1:0] data;
   } crc_ctrl_type;

endpackage

FILE: src/efcrc8_ifs.sv
interface efcrc8_req_if;
   import efcrc8_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0]  frame_length;

   modport source(output valid, func, payload_byte, frame_length, input ready);
   modport sink(input valid, func, payload_byte, frame_length, output ready);
endinterface

interface efcrc8_rsp_if;
   import efcrc8_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              run_last;
   logic              frame_end;

   modport source(output valid, frame_byte, run_last, frame_end, input ready);
   modport sink(input valid, frame_byte, run_last, frame_end, output ready);
endinterface

FILE: src/efcrc8_crc_unit.sv
module efcrc8_crc_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  efcrc8_pkg::crc_ctrl_type     crc_ctrl,
   output logic [efcrc8_pkg::BYTE_W-1:0] crc_value
);
   import efcrc8_pkg::*;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

   logic [BYTE_W-1:0] crc_ff;
   logic [BYTE_W-1:0] crc_in;
   logic [BYTE_W-1:0] crc_next;

   // MSB-first bitwise CRC-8 over one byte
   always_comb begin
      crc_next = crc_ff ^ crc_ctrl.data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (crc_next[BYTE_W-1]) begin
            crc_next = {crc_next[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc_next = {crc_next[BYTE_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (crc_ctrl.clear) begin
         crc_in = '0;
      end else if (crc_ctrl.update) begin
         crc_in = crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

FILE: src/efcrc8_seq.sv
module efcrc8_seq #(
   parameter int unsigned MAX_PAYLOAD = efcrc8_pkg::MAX_PAYLOAD_DEF,
   parameter int unsigned MIN_PAYLOAD = efcrc8_pkg::MIN_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [efcrc8_pkg::ADDR_W-1:0] dest_addr,
   input  logic [efcrc8_pkg::ADDR_W-1:0] src_addr,
   input  logic [efcrc8_pkg::BYTE_W-1:0] crc_value,
   output efcrc8_pkg::crc_ctrl_type      crc_ctrl,
   efcrc8_req_if.sink                    req,
   efcrc8_rsp_if.source                  rsp
);
   import efcrc8_pkg::*;

   localparam int unsigned BLW      = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned PCW      = $clog2(MIN_PAYLOAD + 1);
   localparam int unsigned HDR_LEN  = 22;
   localparam int unsigned HCW      = $clog2(HDR_LEN);
   localparam int unsigned SFD_IDX  = 7;
   localparam int unsigned SH_W     = 2 * ADDR_W + 2 * BYTE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HDR  = 2'd1;
   localparam logic [1:0] ST_PAD  = 2'd2;
   localparam logic [1:0] ST_CRC  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [HCW-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [SH_W-1:0]   shift_ff, shift_in;
   logic [BLW-1:0]    bytes_left_ff, bytes_left_in;
   logic [PCW-1:0]    count_ff, count_in;
   logic              in_frame_ff, in_frame_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              advance;
   logic [LEN_W-1:0]  len_sat;
   logic [PCW-1:0]    count_sat;
   logic [BLW-1:0]    bytes_left_dec;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance && (state_ff == ST_IDLE);

   assign len_sat = (req.frame_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                              : req.frame_length;
   assign count_sat = (count_ff < PCW'(MIN_PAYLOAD)) ? count_ff + PCW'(1) : count_ff;
   assign bytes_left_dec = (bytes_left_ff != '0) ? bytes_left_ff - BLW'(1) : bytes_left_ff;

   always_comb begin
      state_in      = state_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      count_in      = count_ff;
      in_frame_in   = in_frame_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;
      crc_ctrl      = '0;
      if (advance) begin
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  if (!req.func) begin
                     if (req.frame_length != '0) begin
                        state_in      = ST_HDR;
                        hdr_cnt_in    = HCW'(1);
                        shift_in      = {dest_addr, src_addr, 16'(len_sat)};
                        bytes_left_in = BLW'(len_sat);
                        count_in      = '0;
                        in_frame_in   = 1'b1;
                        crc_ctrl.clear = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = PREAMBLE_BYTE;
                        rsp_last_in   = 1'b0;
                        rsp_end_in    = 1'b0;
                     end
                  end else if (in_frame_ff) begin
                     crc_ctrl.update = 1'b1;
                     crc_ctrl.data   = req.payload_byte;
                     rsp_valid_in    = 1'b1;
                     rsp_byte_in     = req.payload_byte;
                     rsp_end_in      = 1'b0;
                     count_in        = count_sat;
                     bytes_left_in   = bytes_left_dec;
                     rsp_last_in     = (bytes_left_dec != '0);
                     if (bytes_left_dec == '0) begin
                        state_in = (count_sat < PCW'(MIN_PAYLOAD)) ? ST_PAD : ST_CRC;
                     end
                  end
               end
            end
            ST_HDR: begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = 1'b0;
               rsp_last_in  = (hdr_cnt_ff == HCW'(HDR_LEN - 1));
               if (hdr_cnt_ff < HCW'(SFD_IDX)) begin
                  rsp_byte_in = PREAMBLE_BYTE;
               end else if (hdr_cnt_ff == HCW'(SFD_IDX)) begin
                  rsp_byte_in = SFD_BYTE;
               end else begin
                  rsp_byte_in     = shift_ff[SH_W-1 -: BYTE_W];
                  crc_ctrl.update = 1'b1;
                  crc_ctrl.data   = shift_ff[SH_W-1 -: BYTE_W];
                  shift_in        = {shift_ff[SH_W-BYTE_W-1:0], BYTE_W'(0)};
               end
               if (hdr_cnt_ff == HCW'(HDR_LEN - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + HCW'(1);
               end
            end
            ST_PAD: begin
               rsp_valid_in    = 1'b1;
               rsp_byte_in     = '0;
               rsp_last_in     = 1'b0;
               rsp_end_in      = 1'b0;
               crc_ctrl.update = 1'b1;
               crc_ctrl.data   = '0;
               count_in        = count_sat;
               if (count_sat >= PCW'(MIN_PAYLOAD)) begin
                  state_in = ST_CRC;
               end
            end
            ST_CRC: begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = crc_value;
               rsp_last_in    = 1'b1;
               rsp_end_in     = 1'b1;
               crc_ctrl.clear = 1'b1;
               in_frame_in    = 1'b0;
               count_in       = '0;
               state_in       = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hdr_cnt_ff    <= '0;
         bytes_left_ff <= '0;
         count_ff      <= '0;
         in_frame_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         bytes_left_ff <= bytes_left_in;
         count_ff      <= count_in;
         in_frame_ff   <= in_frame_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.frame_byte = rsp_byte_ff;
   assign rsp.run_last   = rsp_last_ff;
   assign rsp.frame_end  = rsp_end_ff;

endmodule

FILE: src/ethernet_style_framer_crc8_top.sv
// The first output byte of a transfer that gives output is registered in the cycle after it.
// Throughput: one output byte per cycle while rsp ready is high, from a single shared CRC-8
// byte unit and output register. A start sends a 22-byte header.
// req ready stays low while the header, padding or CRC byte sequence runs.
// Reset: synchronous, active high; clears the sequencer, CRC and output valid, loads default
// addresses. No clearing pass.
module ethernet_style_framer_crc8_top #(
   parameter int unsigned MAX_PAYLOAD = efcrc8_pkg::MAX_PAYLOAD_DEF,
   parameter int unsigned MIN_PAYLOAD = efcrc8_pkg::MIN_PAYLOAD_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   efcrc8_req_if.sink                       req_ch,
   efcrc8_rsp_if.source                     rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [efcrc8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efcrc8_pkg::ADDR_W-1:0]    csr_write_data
);
   import efcrc8_pkg::*;

   logic [ADDR_W-1:0] dest_addr_ff, dest_addr_in;
   logic [ADDR_W-1:0] src_addr_ff, src_addr_in;
   logic [BYTE_W-1:0] crc_value;
   crc_ctrl_type      crc_ctrl;

   always_comb begin
      dest_addr_in = dest_addr_ff;
      src_addr_in  = src_addr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEST_ADDR: dest_addr_in = csr_write_data;
            CSR_SRC_ADDR:  src_addr_in  = csr_write_data;
            default: begin
               dest_addr_in = dest_addr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_addr_ff <= DEST_ADDR_RESET;
         src_addr_ff  <= SRC_ADDR_RESET;
      end else begin
         dest_addr_ff <= dest_addr_in;
         src_addr_ff  <= src_addr_in;
      end
   end

   efcrc8_seq #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .MIN_PAYLOAD(MIN_PAYLOAD)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .dest_addr (dest_addr_ff),
      .src_addr  (src_addr_ff),
      .crc_value (crc_value),
      .crc_ctrl  (crc_ctrl),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   efcrc8_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .crc_ctrl  (crc_ctrl),
      .crc_value (crc_value)
   );

`ifndef ASSERT_OFF
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_end) |-> rsp_ch.run_last)
      else $error("frame end without run last");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request ready while output stalled");

   a_crc_ctrl_excl: assert property (@(posedge clock) disable iff (reset)
      !(crc_ctrl.clear && crc_ctrl.update))
      else $error("crc clear and update together");

   a_reset_no_valid: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("output valid after reset");
`endif

endmodule

FILE: sim/ethernet_style_framer_crc8_top_tb.sv
module ethernet_style_framer_crc8_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import efcrc8_pkg::*;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;
   localparam int   STUCK_LIMIT = 3000;
   localparam int   SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              run_last;
      logic              frame_end;
   } out_byte_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEST_ADDR;
   logic [ADDR_W-1:0]    csr_write_data = '0;

   efcrc8_req_if req_bus();
   efcrc8_rsp_if rsp_bus();

   ethernet_style_framer_crc8_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus.sink),
      .rsp_ch           (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // framer state as predicted
   logic [ADDR_W-1:0] fr_dest = DEST_ADDR_RESET;
   logic [ADDR_W-1:0] fr_src  = SRC_ADDR_RESET;
   logic              fr_open = 1'b0;
   logic [7:0]        fr_crc  = '0;
   logic [LEN_W-1:0]  fr_left = '0;
   logic [5:0]        fr_count = '0;

   out_byte_type bytes_due[$];
   out_byte_type pend;
   bit           pend_ok = 1'b0;
   out_byte_type got_due;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_left     = 0;
   int stuck_cycles  = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int useful_items  = 0;
   int results_seen  = 0;
   int frames_closed = 0;
   int csr_writes    = 0;

   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = (v << 1) ^ 8'h07;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

   // the byte is held back one step so the last one of a transfer can be flagged
   function automatic void queue_byte(input logic [7:0] b, input bit fold, input bit closes);
      if (pend_ok) bytes_due.push_back(pend);
      pend.frame_byte = b;
      pend.run_last   = 1'b0;
      pend.frame_end  = closes;
      pend_ok = 1'b1;
      if (fold) fr_crc = crc8_fold(fr_crc, b);
   endfunction

   function automatic void frame_model_step(input logic func, input logic [7:0] pb,
                                            input logic [LEN_W-1:0] flen);
      logic [LEN_W-1:0] len;
      if (func == FUNC_START) begin
         if (flen != 0) begin
            len = (flen > MAX_PAYLOAD_DEF) ? LEN_W'(MAX_PAYLOAD_DEF) : flen;
            fr_open  = 1'b1;
            fr_crc   = '0;
            fr_left  = len;
            fr_count = '0;
            for (int i = 0; i < 7; i++) queue_byte(PREAMBLE_BYTE, 1'b0, 1'b0);
            queue_byte(SFD_BYTE, 1'b0, 1'b0);
            for (int i = 5; i >= 0; i--) queue_byte(fr_dest[8*i +: 8], 1'b1, 1'b0);
            for (int i = 5; i >= 0; i--) queue_byte(fr_src[8*i +: 8], 1'b1, 1'b0);
            queue_byte({5'b0, len[10:8]}, 1'b1, 1'b0);
            queue_byte(len[7:0], 1'b1, 1'b0);
         end
      end else if (fr_open) begin
         queue_byte(pb, 1'b1, 1'b0);
         if (fr_count < MIN_PAYLOAD_DEF) fr_count++;
         if (fr_left > 0) fr_left--;
         if (fr_left == 0) begin
            while (fr_count < MIN_PAYLOAD_DEF) begin
               queue_byte(8'h00, 1'b1, 1'b0);
               fr_count++;
            end
            queue_byte(fr_crc, 1'b0, 1'b1);
            fr_open  = 1'b0;
            fr_crc   = '0;
            fr_count = '0;
         end
      end
      if (pend_ok) begin
         pend.run_last = 1'b1;
         bytes_due.push_back(pend);
         pend_ok = 1'b0;
         useful_items++;
      end
   endfunction

   task automatic send_item(input logic func, input logic [7:0] pb, input logic [LEN_W-1:0] flen);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.func         <= func;
      req_bus.payload_byte <= pb;
      req_bus.frame_length <= flen;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
      frame_model_step(func, pb, flen);
   endtask

   task automatic send_start(input logic [LEN_W-1:0] len);
      send_item(FUNC_START, 8'($urandom_range(255)), len);
   endtask

   task automatic send_data(input logic [7:0] b);
      send_item(FUNC_DATA, b, LEN_W'($urandom_range(2047)));
   endtask

   task automatic send_frame(input int len);
      send_start(LEN_W'(len));
      repeat (len) send_data(8'($urandom_range(255)));
   endtask

   task automatic wait_idle(input int extra);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DEST_ADDR) begin
         fr_dest = data;
      end else begin
         fr_src = data;
      end
      csr_writes++;
   endtask

   task automatic write_addresses(input logic [ADDR_W-1:0] dest, input logic [ADDR_W-1:0] src);
      wait_idle(SETTLE_CYCLES);
      write_csr(CSR_DEST_ADDR, dest);
      write_csr(CSR_SRC_ADDR, src);
   endtask

   task automatic test_special_cases();
      send_start(11'd0);
      send_data(8'h3C);
      send_start(11'h7FF);
      send_data(8'hFF);
      send_data(8'h00);
      send_start(11'd3);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h81);
      send_start(11'd1);
      send_data(8'h55);
      send_start(11'd1500);
      send_data(8'hAA);
      send_start(11'd2);
      send_start(11'd0);
      send_data(8'h7E);
      send_data(8'hC3);
   endtask

   task automatic test_padding_boundary();
      send_frame(MIN_PAYLOAD_DEF - 1);
      send_frame(MIN_PAYLOAD_DEF);
      send_frame(MIN_PAYLOAD_DEF + 1);
   endtask

   task automatic test_address_registers();
      write_addresses('0, '1);
      send_frame(2);
      write_addresses('1, '0);
      send_frame(1);
      write_addresses(ADDR_W'({$urandom(), $urandom()}), ADDR_W'({$urandom(), $urandom()}));
      send_frame(5);
   endtask

   task automatic test_backpressure();
      wait_idle(0);
      @(posedge clock);
      hold_left = 200;
      send_frame(30);
   endtask

   task automatic test_sender_pause();
      send_start(11'd20);
      repeat (8) send_data(8'($urandom_range(255)));
      wait_idle(0);
      repeat (12) send_data(8'($urandom_range(255)));
   endtask

   task automatic test_max_frame();
      send_start(11'd1600);
      repeat (40) send_data(8'($urandom_range(255)));
   endtask

   task automatic send_random_frame(input bit broken);
      int len;
      int nsend;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         len = $urandom_range(50, 1);
      end else if (pick < 92) begin
         len = $urandom_range(130, 51);
      end else begin
         len = $urandom_range(2047);
      end
      send_start(LEN_W'(len));
      if (broken || len > 130) begin
         nsend = $urandom_range(40);
         if (len > 0) nsend = nsend % len;
      end else begin
         nsend = len;
      end
      repeat (nsend) send_data(8'($urandom_range(255)));
   endtask

   task automatic test_random_traffic(input int quota);
      int mark;
      int r;
      write_addresses(ADDR_W'({$urandom(), $urandom()}), ADDR_W'({$urandom(), $urandom()}));
      mark = useful_items;
      while (useful_items - mark < quota) begin
         r = $urandom_range(99);
         if (r < 6) begin
            if (!fr_open) begin
               send_data(8'($urandom_range(255)));
            end else begin
               send_start(11'd0);
            end
         end else begin
            send_random_frame(r < 16);
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (bytes_due.size() == 0) begin
            $error("unexpected output transfer: frame_byte %02h", rsp_bus.frame_byte);
            error_count++;
         end else begin
            got_due = bytes_due.pop_front();
            if (rsp_bus.frame_byte !== got_due.frame_byte) begin
               $error("frame_byte mismatch: expected %02h, actual %02h",
                      got_due.frame_byte, rsp_bus.frame_byte);
               error_count++;
            end
            if (rsp_bus.run_last !== got_due.run_last) begin
               $error("run_last mismatch: expected %0b, actual %0b",
                      got_due.run_last, rsp_bus.run_last);
               error_count++;
            end
            if (rsp_bus.frame_end !== got_due.frame_end) begin
               $error("frame_end mismatch: expected %0b, actual %0b",
                      got_due.frame_end, rsp_bus.frame_end);
               error_count++;
            end
            if (got_due.frame_end) frames_closed++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $error("no transfer for %0d cycles, %0d bytes still due", STUCK_LIMIT, bytes_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_START;
      req_bus.payload_byte = '0;
      req_bus.frame_length = '0;
      rsp_bus.ready        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      rsp_idle_pct  = 51;
      test_special_cases();
      test_padding_boundary();
      test_address_registers();
      test_random_traffic(40);
      test_backpressure();
      test_sender_pause();

      send_idle_pct = 51;
      rsp_idle_pct  = 31;
      test_random_traffic(40);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_max_frame();
      test_random_traffic(40);

      wait_idle(SETTLE_CYCLES);
      if (bytes_due.size() != 0) begin
         $error("%0d expected bytes never arrived", bytes_due.size());
         error_count++;
      end
      $display("Run covered %0d input transfers (%0d producing output) and %0d output bytes,",
               items_sent, useful_items, results_seen);
      $display("with %0d frames closed by a CRC byte and %0d address register writes.",
               frames_closed, csr_writes);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
